@@ hw/rtl/multicast_mac_secret_decoder_macros.svh @@
// Assertion macros used by the decoder's top-level RTL file.
`ifndef MULTICAST_MAC_SECRET_DECODER_MACROS_SVH
`define MULTICAST_MAC_SECRET_DECODER_MACROS_SVH

// The antecedent holding at a clock edge implies the consequent at the same edge.
`define MMSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The antecedent holding at a clock edge implies the consequent at the next edge.
`define MMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/mmsd_pkg.sv @@
// Types and constants shared by the multicast MAC secret decoder.
package mmsd_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned LEN_W       = 7;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned OQ_DEPTH    = 4;

  localparam logic [7:0]  THRESHOLD_RESET = 8'd10;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;
  localparam logic [47:0] PREFIX_DEST     = 48'h01005E4E5850;
  localparam logic [31:0] DATA_HEAD       = 32'h01005E5E;
  localparam logic [7:0]  LENGTH_MARK     = 8'hFF;

  typedef enum logic [1:0] {
    FRM_PREFIX,
    FRM_LENGTH,
    FRM_DATA,
    FRM_OTHER
  } frame_kind_t;

  typedef enum logic {
    DRAIN_IDLE,
    DRAIN_RUN
  } drain_state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [MAC_W-1:0] bssid;
  } drain_cmd_t;

  typedef struct packed {
    logic busy;
    logic read_pending;
  } drain_status_t;

endpackage

@@ hw/rtl/mmsd_front.sv @@
// Front end: takes frames, classifies them and keeps the decoder's control state.
module mmsd_front #(
  parameter int unsigned MAX_LEN = mmsd_pkg::MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [47:0]            source_address,
  input  logic [47:0]            dest_address,
  input  logic [47:0]            network_bssid,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_data,
  output mmsd_pkg::store_wr_t    store_wr,
  output logic                   cmd_push,
  output mmsd_pkg::drain_cmd_t   cmd,
  input  logic                   cmd_full
);
  import mmsd_pkg::*;

  localparam logic [7:0] MAX_LEN_B = 8'(MAX_LEN);

  // Frame held for its update cycle.
  logic             in_valid;
  logic [MAC_W-1:0] in_src;
  logic [MAC_W-1:0] in_dst;
  logic [MAC_W-1:0] in_bss;

  logic [7:0]             threshold;
  logic [7:0]             prefix_count, prefix_count_next;
  logic [MAC_W-1:0]       sender_address, sender_address_next;
  logic [MAC_W-1:0]       latched_bssid, latched_bssid_next;
  logic                   length_known, length_known_next;
  logic [LEN_W-1:0]       expected_length, expected_length_next;
  logic [LEN_W-1:0]       received_count, received_count_next;
  logic [STORE_DEPTH-1:0] slot_written, slot_written_next;
  logic                   emitted, emitted_next;

  frame_kind_t      kind;
  logic [7:0]       b4;
  logic [7:0]       b5;
  logic             same_sender;
  logic             eligible;
  logic             data_hit;
  logic             completes;
  logic             stall;
  logic [LEN_W-1:0] count_inc;

  assign b4          = in_dst[15:8];
  assign b5          = in_dst[7:0];
  assign same_sender = (in_src == sender_address);
  assign eligible    = (prefix_count > threshold) && same_sender;
  assign count_inc   = received_count + LEN_W'(1);

  always_comb begin
    if (in_dst == PREFIX_DEST) begin
      kind = FRM_PREFIX;
    end else if (in_dst[47:16] == DATA_HEAD && b4 == LENGTH_MARK) begin
      kind = FRM_LENGTH;
    end else if (in_dst[47:16] == DATA_HEAD) begin
      kind = FRM_DATA;
    end else begin
      kind = FRM_OTHER;
    end
  end

  // A data byte lands in a slot below the length that has not been filled yet.
  assign data_hit  = (kind == FRM_DATA) && eligible && length_known &&
                     (b4 < {1'b0, expected_length}) && !slot_written[b4[IDX_W-1:0]];
  assign completes = data_hit && (count_inc == expected_length) && !emitted;
  assign stall     = completes && cmd_full;

  assign full = in_valid;

  always_comb begin
    prefix_count_next    = prefix_count;
    sender_address_next  = sender_address;
    latched_bssid_next   = latched_bssid;
    length_known_next    = length_known;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    slot_written_next    = slot_written;
    emitted_next         = emitted;
    store_wr             = '0;
    cmd_push             = 1'b0;
    cmd.len              = expected_length;
    cmd.bssid            = latched_bssid;
    if (in_valid && !stall) begin
      unique case (kind)
        FRM_PREFIX: begin
          if (same_sender) begin
            if (prefix_count != COUNT_MAX) begin
              prefix_count_next = prefix_count + 8'd1;
            end
          end else begin
            sender_address_next = in_src;
            latched_bssid_next  = in_bss;
            prefix_count_next   = 8'd1;
          end
        end
        FRM_LENGTH: begin
          if (eligible && !length_known && b5 != 8'd0 && b5 <= MAX_LEN_B) begin
            expected_length_next = b5[LEN_W-1:0];
            length_known_next    = 1'b1;
          end
        end
        FRM_DATA: begin
          if (data_hit) begin
            store_wr.en   = 1'b1;
            store_wr.addr = b4[IDX_W-1:0];
            store_wr.data = b5;
            slot_written_next[b4[IDX_W-1:0]] = 1'b1;
            received_count_next = count_inc;
            if (completes) begin
              emitted_next = 1'b1;
              cmd_push     = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      threshold       <= THRESHOLD_RESET;
      prefix_count    <= '0;
      sender_address  <= '0;
      latched_bssid   <= '0;
      length_known    <= 1'b0;
      expected_length <= '0;
      received_count  <= '0;
      slot_written    <= '0;
      emitted         <= 1'b0;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_data;
      end
      if (push && !in_valid) begin
        in_valid <= 1'b1;
      end else if (in_valid && !stall) begin
        in_valid <= 1'b0;
      end
      prefix_count    <= prefix_count_next;
      sender_address  <= sender_address_next;
      latched_bssid   <= latched_bssid_next;
      length_known    <= length_known_next;
      expected_length <= expected_length_next;
      received_count  <= received_count_next;
      slot_written    <= slot_written_next;
      emitted         <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !in_valid) begin
      in_src <= source_address;
      in_dst <= dest_address;
      in_bss <= network_bssid;
    end
  end

endmodule

@@ hw/rtl/mmsd_cmdq.sv @@
// Two-entry queue of drain commands between the front end and the drain unit.
module mmsd_cmdq (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mmsd_pkg::drain_cmd_t push_cmd,
  output logic                 full,
  input  logic                 pop,
  output logic                 valid,
  output mmsd_pkg::drain_cmd_t pop_cmd
);
  import mmsd_pkg::*;

  drain_cmd_t entries [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign pop_cmd = entries[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (pop && valid) begin
        rp <= ~rp;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wp] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/mmsd_back.sv @@
// Drain unit: holds the secret store and streams it out byte by byte.
module mmsd_back (
  input  logic                    clk,
  input  logic                    rst,
  input  mmsd_pkg::store_wr_t     store_wr,
  input  logic                    cmd_valid,
  input  mmsd_pkg::drain_cmd_t    cmd,
  output logic                    cmd_pop,
  output mmsd_pkg::drain_status_t status,
  output logic                    empty,
  input  logic                    pop,
  output logic [7:0]              secret_byte,
  output logic [5:0]              byte_index,
  output logic [47:0]             bssid_out,
  output logic                    last_byte
);
  import mmsd_pkg::*;

  localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  logic [7:0] mem [STORE_DEPTH];

  drain_state_t     state, state_next;
  logic [LEN_W-1:0] len;
  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] k_inc;
  logic [MAC_W-1:0] bssid;
  logic             issue;
  logic             space;

  // Read stage.
  logic             rd_valid;
  logic [7:0]       rd_data;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_last;

  // Output queue.
  logic [7:0]          oq_byte [OQ_DEPTH];
  logic [IDX_W-1:0]    oq_idx  [OQ_DEPTH];
  logic                oq_last [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] oq_wp;
  logic [OQ_PTR_W-1:0] oq_rp;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                oq_pop;

  assign k_inc = k + LEN_W'(1);
  assign space = (oq_count + OQ_CNT_W'(rd_valid)) < OQ_CNT_W'(OQ_DEPTH);

  always_comb begin
    state_next = state;
    unique case (state)
      DRAIN_IDLE: begin
        if (cmd_valid) begin
          state_next = DRAIN_RUN;
        end
      end
      DRAIN_RUN: begin
        if (space && k_inc == len) begin
          state_next = DRAIN_IDLE;
        end
      end
      default: state_next = DRAIN_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop = 1'b0;
    issue   = 1'b0;
    unique case (state)
      DRAIN_IDLE: cmd_pop = cmd_valid;
      DRAIN_RUN:  issue   = space;
      default: begin
      end
    endcase
  end

  assign status.busy         = (state == DRAIN_RUN) || rd_valid;
  assign status.read_pending = rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DRAIN_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      len   <= cmd.len;
      bssid <= cmd.bssid;
      k     <= '0;
    end else if (issue) begin
      k <= k_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.addr] <= store_wr.data;
    end
    if (issue) begin
      rd_data <= mem[k[IDX_W-1:0]];
      rd_idx  <= k[IDX_W-1:0];
      rd_last <= (k_inc == len);
    end
  end

  assign empty  = (oq_count == '0);
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wp    <= '0;
      oq_rp    <= '0;
      oq_count <= '0;
    end else begin
      if (rd_valid) begin
        oq_wp <= oq_wp + OQ_PTR_W'(1);
      end
      if (oq_pop) begin
        oq_rp <= oq_rp + OQ_PTR_W'(1);
      end
      oq_count <= oq_count + OQ_CNT_W'(rd_valid) - OQ_CNT_W'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      oq_byte[oq_wp] <= rd_data;
      oq_idx[oq_wp]  <= rd_idx;
      oq_last[oq_wp] <= rd_last;
    end
  end

  assign secret_byte = oq_byte[oq_rp];
  assign byte_index  = oq_idx[oq_rp];
  assign last_byte   = oq_last[oq_rp];
  assign bssid_out   = bssid;

endmodule

@@ hw/rtl/multicast_mac_secret_decoder.sv @@
// Top level of the multicast MAC secret decoder.
// The decoder watches sniffed frames (source, destination, BSSID) and recovers a
// secret that a sender spells out in multicast destination addresses. Prefix
// frames build trust in one sender; once its prefix count exceeds the
// prefix_threshold register, that sender may announce the secret length once
// and then deliver one byte per data frame. When every slot below the length
// is filled, the whole secret comes out once, one beat per byte in index
// order, each beat carrying the BSSID latched with the sender and a last_byte
// flag on the final beat. A frame is taken into an input register and applied
// to the decoder state from there; full stays high while a frame is held, and
// the completing data frame is held while the command queue is full. That frame
// hands a drain command across a two-entry queue to the drain unit, which reads
// the 64-byte store through its single read port, one byte per cycle while the
// output queue has room, into a four-beat output queue; an L-byte secret
// therefore leaves as L beats, at one beat per cycle while pop keeps up.
// Frames keep flowing in during the drain. The threshold register is written
// through its own valid/ready channel, which is always ready, and should be
// written only while the decoder is idle.
`include "multicast_mac_secret_decoder_macros.svh"

module multicast_mac_secret_decoder #(
  parameter int unsigned MAX_LEN = mmsd_pkg::MAX_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Frame side.
  input  logic        push,
  output logic        full,
  input  logic [47:0] source_address,
  input  logic [47:0] dest_address,
  input  logic [47:0] network_bssid,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  secret_byte,
  output logic [5:0]  byte_index,
  output logic [47:0] bssid_out,
  output logic        last_byte,
  // Threshold register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import mmsd_pkg::*;

  store_wr_t     store_wr;
  logic          cmd_push;
  drain_cmd_t    cmd_in;
  logic          cmd_full;
  logic          cmd_valid;
  logic          cmd_pop;
  drain_cmd_t    cmd_out;
  drain_status_t drain_status;

  // The register accepts a write beat in every cycle.
  assign cfg_ready = 1'b1;

  mmsd_front #(
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .source_address(source_address),
    .dest_address  (dest_address),
    .network_bssid (network_bssid),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .store_wr      (store_wr),
    .cmd_push      (cmd_push),
    .cmd           (cmd_in),
    .cmd_full      (cmd_full)
  );

  mmsd_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .push    (cmd_push),
    .push_cmd(cmd_in),
    .full    (cmd_full),
    .pop     (cmd_pop),
    .valid   (cmd_valid),
    .pop_cmd (cmd_out)
  );

  mmsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .store_wr   (store_wr),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd_out),
    .cmd_pop    (cmd_pop),
    .status     (drain_status),
    .empty      (empty),
    .pop        (pop),
    .secret_byte(secret_byte),
    .byte_index (byte_index),
    .bssid_out  (bssid_out),
    .last_byte  (last_byte)
  );

  // The store is complete before a drain starts, so nothing writes it during one.
  `MMSD_ASSERT_IMPLIES(a_no_write_in_drain, drain_status.busy, !store_wr.en, "store written during drain")
  // The front end holds the completing frame rather than overrun the command queue.
  `MMSD_ASSERT_IMPLIES(a_cmd_no_overflow, cmd_push, !cmd_full, "drain command pushed into full queue")
  // A secret completes only once, so a command never follows another directly.
  `MMSD_ASSERT_NEXT(a_cmd_single, cmd_push, !cmd_push, "drain command pushed twice in a row")

endmodule
